// ===== sv/assert_macros.svh =====
// Assertion helpers used by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/imhpq_pkg.sv =====
`default_nettype none
package imhpq_pkg;
    localparam int CAPACITY = 256;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = SLOT_W + 1;
    localparam int PRIO_W = 32;
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_RAISE = 3'd1;
    localparam logic [2:0] OP_LOWER = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_COUNT = 3'd5;
    localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
endpackage
`default_nettype wire

// ===== sv/imhpq_ram.sv =====
`default_nettype none
module imhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/indexed_max_heap_priority_queue.sv =====
// Sequence: count requests and requests refused in S_CHECK go to S_DONE; a query passes
// S_POSRD first. A sift visits S_CMP, S_POSRD, S_IDRD and S_PRRD for each neighbor it
// compares, then S_SWAP1 and S_SWAP2 for each level that the entry moves.
// Throughput: one request at a time; busy stays high until the result strobe, so the
// rate is set by the sift loop, one read/compare/swap per level in the heap RAMs.
// Reset: synchronous active low; clears the present bits, the count and max_entries=256.
// The receiver cannot stall: each result is shown for exactly one cycle with o_done.
`default_nettype none
`include "assert_macros.svh"
module indexed_max_heap_priority_queue
    import imhpq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           i_operation,
    input  wire logic [7:0]           i_entry_id,
    input  wire logic signed [31:0]   i_priority_in,
    output logic                      o_done,
    output logic                      o_ok,
    output logic [7:0]                o_id_out,
    output logic signed [31:0]        o_priority_out,
    output logic [8:0]                o_count_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_TOPRD, S_TOPWAIT, S_POSRD, S_IDRD, S_PRRD,
        S_CMP, S_SWAP1, S_SWAP2, S_DONE
    } t_state;

    typedef logic [SLOT_W-1:0] t_slot;

    t_state r_state;
    logic [2:0] r_op;
    logic [7:0] r_id;
    logic signed [31:0] r_prio;
    logic [8:0] r_max;
    logic [CNT_W-1:0] r_count;
    logic [CAPACITY-1:0] r_present;
    logic r_ok;
    logic [7:0] r_id_res;
    logic signed [31:0] r_prio_res;
    logic r_down;        // sift direction
    t_slot r_pos;        // current slot of the moving entry
    t_slot r_oth;        // slot being compared (parent or child)
    logic [1:0] r_phase; // which neighbor is being fetched
    logic signed [31:0] r_best_p;
    t_slot r_best;
    logic [7:0] r_oth_id;
    logic [7:0] r_best_id;
    logic [7:0] r_cur_id;

    // RAM ports
    logic hs_we, so_we, pr_we;
    t_slot hs_wa, hs_ra, so_wa, so_ra, pr_wa, pr_ra, so_wd;
    logic [7:0] hs_wd, hs_rd;
    t_slot so_rd;
    logic signed [31:0] pr_wd, pr_rd;
    logic [31:0] pr_rd_u;

    imhpq_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(hs_we), .i_waddr(hs_wa), .i_wdata(hs_wd),
        .i_raddr(hs_ra), .o_rdata(hs_rd));
    imhpq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot (
        .i_clk(i_clk), .i_we(so_we), .i_waddr(so_wa), .i_wdata(so_wd),
        .i_raddr(so_ra), .o_rdata(so_rd));
    imhpq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_prio (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_wa), .i_wdata(pr_wd),
        .i_raddr(pr_ra), .o_rdata(pr_rd_u));
    assign pr_rd = signed'(pr_rd_u);

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? {23'd0, r_max} : 32'd0;
    assign busy = (r_state != S_IDLE);

    logic [8:0] lim;
    assign lim = (r_max < 9'(CAPACITY)) ? r_max : 9'(CAPACITY);
    wire id_valid = {1'b0, r_id} < lim;

    // Child slot arithmetic, wide enough to detect running past the count.
    logic [CNT_W:0] left_w;
    assign left_w = {1'b0, r_pos, 1'b1};
    wire [CNT_W:0] right_w = left_w + 1'b1;
    wire [CNT_W:0] cnt_w = {1'b0, r_count};

    always_comb begin
        hs_we = 1'b0; hs_wa = r_pos; hs_wd = r_cur_id; hs_ra = r_pos;
        so_we = 1'b0; so_wa = t_slot'(r_id); so_wd = r_pos; so_ra = t_slot'(r_id);
        pr_we = 1'b0; pr_wa = t_slot'(r_id); pr_wd = r_prio; pr_ra = t_slot'(r_id);
        case (r_state)
            S_CHECK: begin
                if (r_op == OP_INSERT && id_valid && !r_present[r_id]
                        && r_count < CNT_W'(CAPACITY)) begin
                    hs_we = 1'b1; hs_wa = t_slot'(r_count); hs_wd = r_id;
                    so_we = 1'b1; so_wd = t_slot'(r_count);
                    pr_we = 1'b1;
                end
                hs_ra = '0;
            end
            S_TOPRD: begin
                hs_ra = t_slot'(r_count);
                pr_ra = t_slot'(hs_rd);
            end
            S_TOPWAIT: begin
                hs_we = 1'b1; hs_wa = '0; hs_wd = hs_rd;
                so_we = 1'b1; so_wa = t_slot'(hs_rd); so_wd = '0;
                // Fetch the priority of the entry that now sits at the top.
                pr_ra = t_slot'(hs_rd);
            end
            S_POSRD: begin
                hs_ra = r_oth;
            end
            S_IDRD: begin
                pr_ra = t_slot'(hs_rd);
            end
            S_SWAP1: begin
                hs_we = 1'b1; hs_wa = r_pos; hs_wd = r_best_id;
                so_we = 1'b1; so_wa = t_slot'(r_best_id); so_wd = r_pos;
            end
            S_SWAP2: begin
                hs_we = 1'b1; hs_wa = r_best; hs_wd = r_cur_id;
                so_we = 1'b1; so_wa = t_slot'(r_cur_id); so_wd = r_best;
            end
            S_DONE: begin
                if (r_ok && (r_op == OP_RAISE || r_op == OP_LOWER)) begin
                    pr_we = 1'b0;
                end
            end
            default: ;
        endcase
        if (r_state == S_CMP && r_phase == 2'd3 && (r_op == OP_RAISE || r_op == OP_LOWER)) begin
            pr_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
            r_state <= S_IDLE;
            r_max <= 9'(CAPACITY);
            r_count <= '0;
            r_present <= '0;
        end else begin
            o_done <= (r_state == S_DONE);
            if (cfg_wr && paddr[2] == REG_MAX_ENTRIES) begin
                r_max <= pwdata[8:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op <= i_operation; r_id <= i_entry_id; r_prio <= i_priority_in;
                        r_ok <= 1'b0; r_id_res <= '0; r_prio_res <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Reads issued here: heap slot 0, slot and priority of r_id.
                    case (r_op)
                        OP_INSERT: begin
                            if (id_valid && !r_present[r_id] && r_count < CNT_W'(CAPACITY)) begin
                                r_present[r_id] <= 1'b1;
                                r_count <= r_count + 1'b1;
                                r_ok <= 1'b1;
                                r_pos <= t_slot'(r_count);
                                r_cur_id <= r_id;
                                r_best_p <= r_prio;
                                r_down <= 1'b0;
                                r_phase <= 2'd0;
                                r_state <= S_CMP;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_RAISE, OP_LOWER, OP_QUERY: begin
                            if (id_valid && r_present[r_id]) begin
                                r_state <= S_POSRD;
                                r_phase <= 2'd3;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                                r_state <= S_TOPRD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_COUNT: begin
                            r_ok <= 1'b1;
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_TOPRD: begin
                    // hs_rd holds the top id; its priority read is issued now.
                    r_id_res <= hs_rd;
                    r_present[hs_rd] <= 1'b0;
                    r_ok <= 1'b1;
                    r_state <= S_TOPWAIT;
                end
                S_TOPWAIT: begin
                    r_prio_res <= pr_rd;
                    if (r_count == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cur_id <= hs_rd;
                        r_pos <= '0;
                        r_id <= hs_rd;
                        r_down <= 1'b1;
                        r_phase <= 2'd2;
                        r_state <= S_IDRD;
                    end
                end
                S_POSRD: begin
                    if (r_phase == 2'd3) begin
                        // so_rd and pr_rd belong to r_id.
                        r_pos <= so_rd;
                        r_cur_id <= r_id;
                        if (r_op == OP_QUERY) begin
                            r_ok <= 1'b1; r_prio_res <= pr_rd; r_state <= S_DONE;
                        end else if ((r_op == OP_RAISE && pr_rd < r_prio)
                                || (r_op == OP_LOWER && pr_rd > r_prio)) begin
                            r_ok <= 1'b1;
                            r_best_p <= r_prio;
                            r_down <= (r_op == OP_LOWER);
                            r_state <= S_CMP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_IDRD;
                    end
                end
                S_IDRD: begin
                    if (r_phase == 2'd2) begin
                        // Priority of the moving entry after a remove or a swap.
                        r_best_p <= pr_rd;
                        r_phase <= 2'd0;
                        r_state <= S_CMP;
                    end else begin
                        r_oth_id <= hs_rd;
                        r_state <= S_PRRD;
                    end
                end
                S_PRRD: begin
                    r_state <= S_CMP;
                    r_phase <= r_phase + 1'b1;
                    // Moving up, the entry takes the parent's slot only when strictly greater.
                    if (!r_down ? (r_best_p > pr_rd) : (pr_rd > r_best_p)) begin
                        r_best <= r_oth; r_best_id <= r_oth_id; r_best_p <= pr_rd;
                    end
                end
                S_CMP: begin
                    // Phase 0: first neighbor; 1: right child or decide; 2: decide; 3: settle.
                    if (r_phase == 2'd3) begin
                        r_phase <= 2'd0;
                    end else if (!r_down) begin
                        if (r_phase == 2'd0) begin
                            r_best <= r_pos;
                            if (r_pos != '0) begin
                                r_oth <= t_slot'((r_pos - 1'b1) >> 1);
                                r_state <= S_POSRD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            if (r_best != r_pos) r_state <= S_SWAP1;
                            else r_state <= S_DONE;
                        end
                    end else begin
                        if (r_phase == 2'd0) begin
                            r_best <= r_pos;
                            if (left_w < cnt_w) begin
                                r_oth <= t_slot'(left_w); r_state <= S_POSRD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else if (r_phase == 2'd1 && right_w < cnt_w) begin
                            r_oth <= t_slot'(right_w); r_state <= S_POSRD;
                        end else begin
                            if (r_best != r_pos) r_state <= S_SWAP1;
                            else r_state <= S_DONE;
                        end
                    end
                end
                S_SWAP1: begin
                    r_state <= S_SWAP2;
                end
                S_SWAP2: begin
                    r_pos <= r_best;
                    // The moving entry keeps its priority; restore it before the next level.
                    r_state <= S_IDRD;
                    r_phase <= 2'd2;
                end
                S_DONE: begin
                    o_ok <= r_ok;
                    o_id_out <= r_id_res;
                    o_priority_out <= r_prio_res;
                    o_count_out <= 9'(r_count);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "count high")
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE, "no idle")
    `ASSERT_IMPL(a_busy_no_done, i_clk, i_rst_n, o_done, !busy, "result while busy")
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import imhpq_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] OP_BAD6 = 3'd6;
    localparam logic [2:0] OP_BAD7 = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [7:0]         id;
        logic signed [31:0] prio;
        logic [8:0]         cnt;
    } t_heap_reply;

    typedef struct {
        logic [2:0]         op;
        logic [7:0]         id;
        logic signed [31:0] prio;
        bit                 has_reply;
        t_heap_reply        reply;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_operation;
    logic [7:0]         i_entry_id;
    logic signed [31:0] i_priority_in;
    logic               o_done;
    logic               o_ok;
    logic [7:0]         o_id_out;
    logic signed [31:0] o_priority_out;
    logic [8:0]         o_count_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    indexed_max_heap_priority_queue uut (.*);

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the heap used to predict every reply.
    logic [7:0]         sh_slots [CAPACITY];
    logic [7:0]         sh_slot_of [CAPACITY];
    logic signed [31:0] sh_prio [CAPACITY];
    bit                 sh_present [CAPACITY];
    int                 sh_count;
    int                 sh_limit;

    t_heap_reply pending_replies [$];
    int  errors = 0;
    int  idle_pct = 0;
    int  stall_cycles = 0;
    int  n_requests = 0;
    int  n_replies = 0;

    function automatic void swap_slots(int a, int b);
        logic [7:0] ia;
        logic [7:0] ib;
        ia = sh_slots[a];
        ib = sh_slots[b];
        sh_slots[a] = ib;
        sh_slots[b] = ia;
        sh_slot_of[ib] = 8'(a);
        sh_slot_of[ia] = 8'(b);
    endfunction

    function automatic void sift_up(int pos);
        int par;
        while (pos > 0 && pos < sh_count) begin
            par = (pos - 1) / 2;
            if (sh_prio[sh_slots[pos]] > sh_prio[sh_slots[par]]) begin
                swap_slots(pos, par);
                pos = par;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down(int pos);
        int best;
        while (pos < sh_count) begin
            best = pos;
            if (2 * pos + 1 < sh_count && sh_prio[sh_slots[2 * pos + 1]] > sh_prio[sh_slots[best]])
                best = 2 * pos + 1;
            if (2 * pos + 2 < sh_count && sh_prio[sh_slots[2 * pos + 2]] > sh_prio[sh_slots[best]])
                best = 2 * pos + 2;
            if (best == pos)
                break;
            swap_slots(pos, best);
            pos = best;
        end
    endfunction

    function automatic t_heap_reply apply_request(logic [2:0] op, logic [7:0] id,
                                                  logic signed [31:0] prio);
        t_heap_reply r;
        bit          id_ok;
        logic [7:0]  top;
        r = '0;
        id_ok = int'(id) < sh_limit;
        case (op)
            OP_INSERT: begin
                if (id_ok && !sh_present[id] && sh_count < CAPACITY) begin
                    sh_present[id] = 1'b1;
                    sh_prio[id] = prio;
                    sh_slots[sh_count] = id;
                    sh_slot_of[id] = 8'(sh_count);
                    sh_count++;
                    sift_up(sh_count - 1);
                    r.ok = 1'b1;
                end
            end
            OP_RAISE: begin
                if (id_ok && sh_present[id] && sh_prio[id] < prio) begin
                    sh_prio[id] = prio;
                    sift_up(sh_slot_of[id]);
                    r.ok = 1'b1;
                end
            end
            OP_LOWER: begin
                if (id_ok && sh_present[id] && sh_prio[id] > prio) begin
                    sh_prio[id] = prio;
                    sift_down(sh_slot_of[id]);
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (sh_count > 0) begin
                    top = sh_slots[0];
                    r.id = top;
                    r.prio = sh_prio[top];
                    sh_present[top] = 1'b0;
                    sh_count--;
                    if (sh_count > 0) begin
                        sh_slots[0] = sh_slots[sh_count];
                        sh_slot_of[sh_slots[0]] = 8'd0;
                        sift_down(0);
                    end
                    r.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                if (id_ok && sh_present[id]) begin
                    r.prio = sh_prio[id];
                    r.ok = 1'b1;
                end
            end
            OP_COUNT: r.ok = 1'b1;
            default: ;
        endcase
        r.cnt = 9'(sh_count);
        return r;
    endfunction

    // Replies are sampled at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_replies++;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply ok=%0b id=%0d prio=%0d cnt=%0d",
                         $time, o_ok, o_id_out, o_priority_out, o_count_out);
            end else begin
                t_heap_reply e;
                e = pending_replies.pop_front();
                if (o_ok !== e.ok) begin
                    errors++;
                    $display("%0t: ok expected %0b actual %0b", $time, e.ok, o_ok);
                end
                if (o_id_out !== e.id) begin
                    errors++;
                    $display("%0t: id expected %0d actual %0d", $time, e.id, o_id_out);
                end
                if (o_priority_out !== e.prio) begin
                    errors++;
                    $display("%0t: priority expected %0d actual %0d", $time, e.prio,
                             o_priority_out);
                end
                if (o_count_out !== e.cnt) begin
                    errors++;
                    $display("%0t: count expected %0d actual %0d", $time, e.cnt,
                             o_count_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("indexed_max_heap_priority_queue: mismatch");
            $finish;
        end
    end

    // start stays high from one request to the next unless an idle gap is drawn.
    task automatic send_request(logic [2:0] op, logic [7:0] id, logic signed [31:0] prio,
                                bit has_reply, t_heap_reply want);
        t_heap_reply got;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_entry_id <= id;
        i_priority_in <= prio;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        got = apply_request(op, id, prio);
        if (has_reply && got !== want) begin
            errors++;
            $display("%0t: table row expected %h predictor %h", $time, want, got);
        end
        pending_replies.push_back(got);
        n_requests++;
    endtask

    task automatic write_limit(int value);
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_ENTRIES, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_limit = value < CAPACITY ? value : CAPACITY;
    endtask

    function automatic logic signed [31:0] rand_prio();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(7)) << 16);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic random_phase(int n, int pct, int id_span);
        logic [2:0] op;
        logic [7:0] id;
        int         pick;
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                op = OP_INSERT;
            else if (pick < 50)
                op = OP_RAISE;
            else if (pick < 65)
                op = OP_LOWER;
            else if (pick < 85)
                op = OP_REMOVE;
            else if (pick < 93)
                op = OP_QUERY;
            else if (pick < 97)
                op = OP_COUNT;
            else
                op = 3'($urandom_range(7));
            id = $urandom_range(3) == 0 ? 8'($urandom()) : 8'($urandom_range(id_span - 1));
            send_request(op, id, rand_prio(), 1'b0, '0);
        end
    endtask

    t_stim_row dir_rows [$];

    function automatic void add_row(logic [2:0] op, logic [7:0] id, logic signed [31:0] prio,
                                    bit has, logic ok, logic [7:0] rid,
                                    logic signed [31:0] rprio, logic [8:0] cnt);
        t_stim_row s;
        s.op = op;
        s.id = id;
        s.prio = prio;
        s.has_reply = has;
        s.reply = '{ok, rid, rprio, cnt};
        dir_rows.push_back(s);
    endfunction

    initial begin
        for (int k = 0; k < CAPACITY; k++)
            sh_present[k] = 1'b0;
        sh_count = 0;
        sh_limit = CAPACITY;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = '0;
        i_entry_id = '0;
        i_priority_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty heap, extremes, ties, rejections and unknown codes.
        add_row(OP_COUNT, 8'd0, 0, 1, 1, 0, 0, 0);
        add_row(OP_REMOVE, 8'd0, 0, 1, 0, 0, 0, 0);
        add_row(OP_QUERY, 8'd5, 0, 1, 0, 0, 0, 0);
        add_row(OP_INSERT, 8'd255, 32'sh7FFF_FFFF, 1, 1, 0, 0, 1);
        add_row(OP_INSERT, 8'd0, 32'sh8000_0000, 1, 1, 0, 0, 2);
        add_row(OP_INSERT, 8'd0, 32'sd5, 1, 0, 0, 0, 2);
        add_row(OP_QUERY, 8'd255, 0, 1, 1, 0, 32'sh7FFF_FFFF, 2);
        add_row(OP_RAISE, 8'd255, 32'sh7FFF_FFFF, 1, 0, 0, 0, 2);
        add_row(OP_LOWER, 8'd0, 32'sh8000_0000, 1, 0, 0, 0, 2);
        add_row(OP_RAISE, 8'd7, 32'sd9, 1, 0, 0, 0, 2);
        add_row(OP_INSERT, 8'd10, 32'sh0001_0000, 0, 0, 0, 0, 0);
        add_row(OP_INSERT, 8'd11, 32'sh0001_0000, 0, 0, 0, 0, 0);
        add_row(OP_INSERT, 8'd12, 32'sh0001_0000, 0, 0, 0, 0, 0);
        add_row(OP_RAISE, 8'd0, 32'sh0002_0000, 0, 0, 0, 0, 0);
        add_row(OP_LOWER, 8'd255, 32'sh8000_0001, 0, 0, 0, 0, 0);
        add_row(OP_BAD6, 8'd1, 32'sd1, 1, 0, 0, 0, 5);
        add_row(OP_BAD7, 8'hAA, 32'shFFFF_FFFF, 1, 0, 0, 0, 5);
        for (int k = 0; k < 5; k++)
            add_row(OP_REMOVE, 8'd0, 0, 0, 0, 0, 0, 0);
        add_row(OP_REMOVE, 8'd0, 0, 1, 0, 0, 0, 0);
        idle_pct = 0;
        foreach (dir_rows[k])
            send_request(dir_rows[k].op, dir_rows[k].id, dir_rows[k].prio,
                         dir_rows[k].has_reply, dir_rows[k].reply);

        random_phase(450, 0, 256);
        write_limit(1);
        // An id still held above a lowered limit must leave only through remove.
        send_request(OP_INSERT, 8'd1, 0, 1'b0, '0);
        random_phase(150, 77, 4);
        write_limit(256);
        random_phase(500, 25, 256);
        write_limit(17);
        random_phase(400, 77, 32);
        write_limit(0);
        random_phase(60, 0, 8);
        write_limit(511);
        random_phase(300, 0, 256);

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        $display("Run covered %0d requests and %0d replies over limits 1, 17, 256, 0, 511.",
                 n_requests, n_replies);
        $display("Idle rates 0, 25 and 77 percent were applied on the request side.");
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("indexed_max_heap_priority_queue: match");
        end else begin
            $display("indexed_max_heap_priority_queue: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
